/* rtl/core/nsp_pkg.sv */
`timescale 1ns / 1ps

package nsp_pkg;

  localparam int REQ_BITS      = 2;
  localparam int REG_BITS      = 11;
  localparam int CFG_IDX_BITS  = 2;
  localparam int IDX_OUT_BITS  = 10;
  localparam int DIST_BITS     = 17;

  localparam logic [REG_BITS-1:0] WIN_END_RESET = 11'd1024;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_code_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WIN_ENABLE = 2'd0,
    CFG_WIN_START  = 2'd1,
    CFG_WIN_END    = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_index_t;

  // status of the square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } nsp_sqrt_stat_t;

endpackage

/* rtl/core/nsp_if.sv */
`timescale 1ns / 1ps

interface nsp_req_if
  import nsp_pkg::*;
#(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic [REQ_BITS-1:0]          req_type;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, req_type, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, req_type, coord_x, coord_y, coord_z, output ready);
endinterface

interface nsp_res_if
  import nsp_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [IDX_OUT_BITS-1:0] nearest_index;
  logic [DIST_BITS-1:0]    distance;
  logic                    empty_res;
  logic                    store_full;

  modport source (output valid, nearest_index, distance, empty_res, store_full, input ready);
  modport sink   (input valid, nearest_index, distance, empty_res, store_full, output ready);
endinterface

/* rtl/core/nsp_isqrt.sv */
`timescale 1ns / 1ps

module nsp_isqrt
  import nsp_pkg::*;
#(
  parameter int IN_W = 34
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [IN_W-1:0]      value,
  output logic [IN_W/2-1:0]    root,
  output nsp_sqrt_stat_t       stat
);

  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 3;
  localparam int CNT_W = $clog2(OUT_W + 1);

  logic [IN_W-1:0]  val;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  // one result bit per cycle, restoring method
  always_comb begin
    rem_sh = {rem[REM_W-3:0], val[IN_W-1 -: 2]};
    trial  = REM_W'({root, 2'b01});
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(OUT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val  <= {val[IN_W-3:0], 2'b00};
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[OUT_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* rtl/core/nearest_skeleton_point.sv */
`timescale 1ns / 1ps
// Nearest skeleton point: brute-force 3-D nearest neighbor over a point store.
// Request channel (req): clear, append or query, with a signed Q11.4 point.
// Result channel (res): nearest index, floor sqrt of the minimum squared
// distance (Q.4), empty flag and a sticky store-full flag. Clear and the
// unused request code give no result; append and query give one.
// Config port: cfg_we/cfg_index/cfg_data set window enable, start and end;
// write only while the block is idle.
// An append is written in the transfer cycle and its result is in the
// output register in the next cycle. A query makes one store read per
// cycle over the searched points through a five-stage distance pipeline,
// then runs the serial square root, one result bit per cycle. Throughput
// is one item at a time.
// Reset clears the point count, the overflow flag and the window registers;
// the store itself is not cleared since entries at or above the count are
// never read.
// Receiver stall: the output register holds one result. A query may still
// run to completion and then waits; an append waits for the register.
module nearest_skeleton_point
  import nsp_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  nsp_req_if.sink                 req,
  nsp_res_if.source               res,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]     cfg_data
);

  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int PTR_W  = (CNT_W > REG_BITS) ? CNT_W : REG_BITS;
  localparam int D_W    = COORD_BITS + 1;
  localparam int SQ_W   = 2 * D_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int PT_W   = 3 * COORD_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_SQRT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic                win_en;
  logic [REG_BITS-1:0] win_start;
  logic [REG_BITS-1:0] win_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_en    <= 1'b0;
      win_start <= '0;
      win_end   <= WIN_END_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_WIN_ENABLE: win_en    <= cfg_data[0];
        CFG_WIN_START:  win_start <= cfg_data;
        CFG_WIN_END:    win_end   <= cfg_data;
        default:        ;
      endcase
    end
  end

  // request decode
  logic      out_free;
  logic      in_xfer;
  req_code_t code;
  logic      out_valid;

  assign code     = req_code_t'(req.req_type);
  assign out_free = !out_valid || res.ready;
  assign req.ready = (state == ST_IDLE) && (out_free || code != REQ_APPEND);
  assign in_xfer  = req.valid && req.ready;

  // point store
  logic [CNT_W-1:0] count;
  logic             overflow;
  logic             has_room;
  logic             mem_we;
  logic [PT_W-1:0]  mem [MAX_POINTS];
  logic [PT_W-1:0]  rdata;
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] scan_end;

  assign has_room = (count < CNT_W'(MAX_POINTS));
  assign mem_we   = in_xfer && code == REQ_APPEND && has_room;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IDX_W-1:0]] <= {req.coord_z, req.coord_y, req.coord_x};
    end
    rdata <= mem[ptr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (in_xfer) begin
      if (code == REQ_CLEAR) begin
        count    <= '0;
        overflow <= 1'b0;
      end else if (code == REQ_APPEND) begin
        if (has_room) count <= count + CNT_W'(1);
        else          overflow <= 1'b1;
      end
    end
  end

  // search range
  logic [PTR_W-1:0] lo_w, cnt_w, we_w, hi_w;

  always_comb begin
    cnt_w = PTR_W'(count);
    we_w  = PTR_W'(win_end);
    lo_w  = win_en ? PTR_W'(win_start) : '0;
    hi_w  = (win_en && we_w < cnt_w) ? we_w : cnt_w;
  end

  // query point
  logic signed [COORD_BITS-1:0] q [3];

  always_ff @(posedge clk) begin
    if (in_xfer && code == REQ_QUERY) begin
      q[0] <= req.coord_x;
      q[1] <= req.coord_y;
      q[2] <= req.coord_z;
    end
  end

  // distance pipeline: read, abs diff, square, sum, compare
  logic             issue;
  logic             v1, v2, v3, v4;
  logic [IDX_W-1:0] idx1, idx2, idx3, idx4;
  logic [D_W-1:0]   absd [3];
  logic [SQ_W-1:0]  sq [3];
  logic [SUM_W-1:0] sum;
  logic             pipe_busy;
  logic             scan_done;

  assign issue     = (state == ST_SCAN) && (ptr < scan_end);
  assign pipe_busy = v1 || v2 || v3 || v4;
  assign scan_done = (state == ST_SCAN) && !issue && !pipe_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && code == REQ_QUERY) begin
      ptr      <= lo_w;
      scan_end <= hi_w;
    end else if (issue) begin
      ptr <= ptr + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    logic signed [D_W-1:0] d;
    idx1 <= ptr[IDX_W-1:0];
    idx2 <= idx1;
    idx3 <= idx2;
    idx4 <= idx3;
    for (int k = 0; k < 3; k++) begin
      d = $signed({q[k][COORD_BITS-1], q[k]})
        - $signed({rdata[k*COORD_BITS + COORD_BITS-1], rdata[k*COORD_BITS +: COORD_BITS]});
      absd[k] <= d[D_W-1] ? D_W'(-d) : D_W'(d);
      sq[k]   <= absd[k] * absd[k];
    end
    sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
  end

  // running minimum; strict compare keeps the lowest index on ties
  logic             found;
  logic [SUM_W-1:0] best_d;
  logic [IDX_W-1:0] best_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (in_xfer && code == REQ_QUERY) begin
      found <= 1'b0;
    end else if (v4) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v4 && (!found || sum < best_d)) begin
      best_d   <= sum;
      best_idx <= idx4;
    end
  end

  // square root
  logic              sqrt_start;
  logic [ROOT_W-1:0] root;
  nsp_sqrt_stat_t    sqrt_stat;

  assign sqrt_start = scan_done && found;

  nsp_isqrt #(
    .IN_W (SUM_W)
  ) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (best_d),
    .root  (root),
    .stat  (sqrt_stat)
  );

  // control
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_xfer && code == REQ_QUERY) state_next = ST_SCAN;
      ST_SCAN: if (scan_done) state_next = found ? ST_SQRT : ST_DONE;
      ST_SQRT: if (sqrt_stat.done) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // output register
  logic                    load_append;
  logic                    load_query;
  logic [IDX_OUT_BITS-1:0] out_idx;
  logic [DIST_BITS-1:0]    out_dist;
  logic                    out_empty;
  logic                    out_full;

  assign load_append = in_xfer && code == REQ_APPEND;
  assign load_query  = (state == ST_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_append || load_query) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_append) begin
      out_idx   <= '0;
      out_dist  <= '0;
      out_empty <= 1'b0;
      out_full  <= overflow || !has_room;
    end else if (load_query) begin
      out_idx   <= found ? IDX_OUT_BITS'(best_idx) : '0;
      out_dist  <= found ? DIST_BITS'(root) : '0;
      out_empty <= !found;
      out_full  <= overflow;
    end
  end

  assign res.valid         = out_valid;
  assign res.nearest_index = out_idx;
  assign res.distance      = out_dist;
  assign res.empty_res     = out_empty;
  assign res.store_full    = out_full;

  // checks
  a_pipe_in_scan: assert property (@(posedge clk) disable iff (rst)
    v4 |-> state == ST_SCAN)
    else $error("distance pipeline active outside scan");

  a_sqrt_in_state: assert property (@(posedge clk) disable iff (rst)
    sqrt_stat.done |-> state == ST_SQRT)
    else $error("square root finished outside its state");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> count == $past(count) + CNT_W'(1))
    else $error("append did not advance the point count");

  a_append_full: assert property (@(posedge clk) disable iff (rst)
    (load_append && !has_room) |=> overflow && out_full)
    else $error("dropped append not flagged");

  a_query_result: assert property (@(posedge clk) disable iff (rst)
    load_query |=> out_valid && (out_empty == !$past(found)))
    else $error("query result not loaded");

endmodule
